// ----- hdl/polyphonic_beep_synth_defines.svh -----
// Assertion macros shared by the beep synthesizer RTL.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef POLYPHONIC_BEEP_SYNTH_DEFINES_SVH
`define POLYPHONIC_BEEP_SYNTH_DEFINES_SVH

// checked only while out of reset
`define PBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// checked at every edge, reset included
`define PBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hdl/pbs_pkg.sv -----
// Package for the polyphonic beep synthesizer: sizes, register indexes,
// reset values and the quarter-wave sine tables. Depends on nothing.
package pbs_pkg;

  localparam int MAX_VOICES       = 8;
  localparam int CHANNELS         = 8;
  localparam int OUT_FIELDS       = 8;
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int SIN_IDX_W        = $clog2(SINE_TABLE_DEPTH);
  localparam int QUARTER          = SINE_TABLE_DEPTH / 4;
  localparam int Q_IDX_W          = SIN_IDX_W - 2;
  localparam int VIDX_W           = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;

  localparam int SAMPLE_W   = 19;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = OUT_FIELDS * SAMPLE_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_RECIP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_RECIP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_DURATION  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP      = 2'd3;

  localparam logic [15:0] ATTACK_RECIP_RST  = 16'd273;
  localparam logic [15:0] RELEASE_RECIP_RST = 16'd45;
  localparam logic [23:0] MIN_DURATION_RST  = 24'd2400;
  localparam logic [30:0] MIN_STEP_RST      = 31'd1789570;

  localparam logic [16:0] FULL_Q16 = 17'h10000;
  localparam logic signed [19:0] OUT_MAX = 20'sd262143;
  localparam logic signed [19:0] OUT_MIN = -20'sd262144;
  localparam logic signed [17:0] TONE_C1 = 18'sd26214;
  localparam logic signed [17:0] TONE_C3 = 18'sd6554;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  typedef logic [QUARTER-1:0][15:0] qtab_t;

  // sin(x) on [0, pi/2], Q30 in and out, Taylor series to x^13
  function automatic longint unsigned sine_q30(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint          sum;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    for (int k = 1; k <= 6; k++) begin
      term = (term * x2) >> 30;
      case (k)
        1:       term = term / 6;
        2:       term = term / 20;
        3:       term = term / 42;
        4:       term = term / 72;
        5:       term = term / 110;
        default: term = term / 156;
      endcase
      if (k % 2 == 1) sum = sum - longint'(term);
      else            sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'd0 : longint'(sum);
  endfunction

  // magnitude for quarter index j; mirror gives the falling quarter
  function automatic logic [15:0] sine_entry(int j, bit mirror);
    longint unsigned rem;
    longint unsigned x;
    longint unsigned q15;
    rem = longint'(4 * j);
    x   = (rem * HALF_PI_Q30) / SINE_TABLE_DEPTH;
    if (mirror) x = HALF_PI_Q30 - x;
    q15 = (sine_q30(x) + 64'd16384) >> 15;
    if (q15 > 64'd32767) q15 = 64'd32767;
    return q15[15:0];
  endfunction

  function automatic qtab_t build_qtab(bit mirror);
    qtab_t tab;
    for (int j = 0; j < QUARTER; j++) tab[j] = sine_entry(j, mirror);
    return tab;
  endfunction

  localparam qtab_t SINE_RISE = build_qtab(1'b0);
  localparam qtab_t SINE_FALL = build_qtab(1'b1);

  function automatic logic signed [15:0] sine_lookup(logic [31:0] phase);
    logic [SIN_IDX_W-1:0] idx;
    logic [1:0]           quad;
    logic [Q_IDX_W-1:0]   j;
    logic [15:0]          mag;
    idx  = phase[31 -: SIN_IDX_W];
    quad = idx[SIN_IDX_W-1 -: 2];
    j    = idx[Q_IDX_W-1:0];
    mag  = quad[0] ? SINE_FALL[j] : SINE_RISE[j];
    return quad[1] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

// ----- hdl/polyphonic_beep_synth.sv -----
// Polyphonic beep synthesizer top level: voice store, sequencer and one
// shared multiplier. Depends on pbs_pkg and polyphonic_beep_synth_defines.svh.
//
// Usage:
//   s_axis carries requests. tuser is the kind: 0 starts a beep, 1 asks for
//   one output frame. A beep request replaces the first idle voice, or the
//   voice with the fewest frames left (lowest index on a tie).
//   m_axis carries one frame of eight 19-bit signed channel sums per tick.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the envelope and floor registers;
//   write them only while no request is in progress.
// Timing:
//   The block takes one request at a time; s_axis_tready is low until done.
//   Beep: a scan of the voices, one per cycle, then the write of the chosen voice.
//   Tick: each voice that sounds passes ATK, REL, ENV, GAIN, TONE1, TONE3, MIX
//   and ADD, using the one shared multiplier seven times; an idle voice only ATK.
//   The frame sits in an output register; when the receiver stalls a beep
//   can still be taken, and the next tick waits at its end for the register.
// Reset: all voices idle, registers at their defaults, no frame pending.
`include "polyphonic_beep_synth_defines.svh"

module polyphonic_beep_synth (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [31:0] phase_step, [55:32] duration_frames, [72:56] gain,
  // [80:73] channel_mask, [87:81] zero
  input  logic [pbs_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [0] kind
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // 19 bits each from bit 0: front_left, front_right, centre, subwoofer,
  // back_left, back_right, side_left, side_right
  output logic [pbs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                            cfg_we_i,
  input  logic [pbs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [pbs_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_WRITE = 4'd2;
  localparam logic [3:0] S_ATK   = 4'd3;
  localparam logic [3:0] S_REL   = 4'd4;
  localparam logic [3:0] S_ENV   = 4'd5;
  localparam logic [3:0] S_GAIN  = 4'd6;
  localparam logic [3:0] S_TONE1 = 4'd7;
  localparam logic [3:0] S_TONE3 = 4'd8;
  localparam logic [3:0] S_MIX   = 4'd9;
  localparam logic [3:0] S_ADD   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  localparam logic [pbs_pkg::VIDX_W-1:0] VLAST = pbs_pkg::VIDX_W'(pbs_pkg::MAX_VOICES - 1);

  logic [3:0] state_q, state_d;
  logic [pbs_pkg::VIDX_W-1:0] vidx_q, best_q;
  logic [23:0] best_left_q;

  logic [15:0] attack_q, release_q;
  logic [23:0] min_dur_q;
  logic [30:0] min_step_q;

  logic [31:0] voice_phase_q    [pbs_pkg::MAX_VOICES];
  logic [31:0] voice_step_q     [pbs_pkg::MAX_VOICES];
  logic [23:0] voice_duration_q [pbs_pkg::MAX_VOICES];
  logic [23:0] voice_elapsed_q  [pbs_pkg::MAX_VOICES];
  logic [16:0] voice_gain_q     [pbs_pkg::MAX_VOICES];
  logic [7:0]  voice_mask_q     [pbs_pkg::MAX_VOICES];

  logic [31:0] step_q;
  logic [23:0] dur_q;
  logic [16:0] gain_q;
  logic [7:0]  mask_q;

  logic [16:0] a_q, r_q, env_q, g_q;
  logic signed [15:0] s1_q, s3_q;
  logic signed [31:0] acc_q;
  logic signed [17:0] tone_q;
  logic signed [16:0] samp_q;
  logic signed [pbs_pkg::SAMPLE_W-1:0] sum_q [pbs_pkg::OUT_FIELDS];

  logic                           m_valid_q;
  logic [pbs_pkg::OUT_DATA_W-1:0] m_data_q;

  // current voice view
  logic [23:0] cur_el, cur_dur, cur_left;
  logic [31:0] cur_phase, phase3;
  logic        sounding, accept, out_free;

  assign cur_el    = voice_elapsed_q[vidx_q];
  assign cur_dur   = voice_duration_q[vidx_q];
  assign cur_phase = voice_phase_q[vidx_q];
  assign cur_left  = cur_dur - cur_el;
  assign sounding  = cur_el < cur_dur;
  assign phase3    = cur_phase + {cur_phase[30:0], 1'b0};

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  // shared multiplier
  logic signed [24:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [42:0] prod;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_ATK: begin
        mul_a = $signed({1'b0, cur_el});
        mul_b = $signed({2'b00, attack_q});
      end
      S_REL: begin
        mul_a = $signed({1'b0, cur_left});
        mul_b = $signed({2'b00, release_q});
      end
      S_ENV: begin
        mul_a = $signed({8'd0, a_q});
        mul_b = $signed({1'b0, r_q});
      end
      S_GAIN: begin
        mul_a = $signed({8'd0, voice_gain_q[vidx_q]});
        mul_b = $signed({1'b0, env_q});
      end
      S_TONE1: begin
        mul_a = 25'(s1_q);
        mul_b = pbs_pkg::TONE_C1;
      end
      S_TONE3: begin
        mul_a = 25'(s3_q);
        mul_b = pbs_pkg::TONE_C3;
      end
      S_MIX: begin
        mul_a = $signed({8'd0, g_q});
        mul_b = tone_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = 43'(mul_a) * 43'(mul_b);

  logic [16:0] prod_clamp;
  logic signed [32:0] tone_sum;
  logic signed [42:0] samp_round;

  assign prod_clamp = (prod > 43'sd65536) ? pbs_pkg::FULL_Q16 : prod[16:0];
  assign tone_sum   = 33'(acc_q) + 33'($signed(prod[31:0])) + 33'sd16384;
  assign samp_round = prod + 43'sd32768;

  // next voice or the end of the frame
  logic [3:0] after_voice;
  assign after_voice = (vidx_q == VLAST) ? S_OUT : S_ATK;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = s_axis_tuser ? S_ATK : S_SCAN;
      S_SCAN:  if (!sounding || vidx_q == VLAST) state_d = S_WRITE;
      S_WRITE: state_d = S_IDLE;
      S_ATK:   state_d = sounding ? S_REL : after_voice;
      S_REL:   state_d = S_ENV;
      S_ENV:   state_d = S_GAIN;
      S_GAIN:  state_d = S_TONE1;
      S_TONE1: state_d = S_TONE3;
      S_TONE3: state_d = S_MIX;
      S_MIX:   state_d = S_ADD;
      S_ADD:   state_d = after_voice;
      S_OUT:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic [31:0] in_step;
  logic [23:0] in_dur;
  logic [16:0] in_gain;
  assign in_step = s_axis_tdata[31:0];
  assign in_dur  = s_axis_tdata[55:32];
  assign in_gain = s_axis_tdata[72:56];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vidx_q      <= '0;
      best_q      <= '0;
      best_left_q <= '0;
      attack_q    <= pbs_pkg::ATTACK_RECIP_RST;
      release_q   <= pbs_pkg::RELEASE_RECIP_RST;
      min_dur_q   <= pbs_pkg::MIN_DURATION_RST;
      min_step_q  <= pbs_pkg::MIN_STEP_RST;
      m_valid_q   <= 1'b0;
      for (int v = 0; v < pbs_pkg::MAX_VOICES; v++) begin
        voice_phase_q[v]    <= '0;
        voice_step_q[v]     <= '0;
        voice_duration_q[v] <= '0;
        voice_elapsed_q[v]  <= '0;
        voice_gain_q[v]     <= '0;
        voice_mask_q[v]     <= '0;
      end
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pbs_pkg::REG_ATTACK_RECIP:  attack_q   <= cfg_data_i[15:0];
          pbs_pkg::REG_RELEASE_RECIP: release_q  <= cfg_data_i[15:0];
          pbs_pkg::REG_MIN_DURATION:  min_dur_q  <= cfg_data_i[23:0];
          pbs_pkg::REG_MIN_STEP:      min_step_q <= cfg_data_i[30:0];
          default: ;
        endcase
      end

      if (state_q == S_OUT && out_free) m_valid_q <= 1'b1;
      else if (m_axis_tready)           m_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            step_q  <= (in_step < {1'b0, min_step_q}) ? {1'b0, min_step_q} : in_step;
            dur_q   <= (in_dur < min_dur_q) ? min_dur_q : in_dur;
            gain_q  <= (in_gain > pbs_pkg::FULL_Q16) ? pbs_pkg::FULL_Q16 : in_gain;
            mask_q  <= s_axis_tdata[80:73];
            vidx_q  <= '0;
            best_q  <= '0;
            for (int c = 0; c < pbs_pkg::OUT_FIELDS; c++) sum_q[c] <= '0;
          end
        end
        S_SCAN: begin
          if (!sounding) begin
            best_q <= vidx_q;
          end else begin
            if (vidx_q == '0 || cur_left < best_left_q) begin
              best_q      <= vidx_q;
              best_left_q <= cur_left;
            end
            if (vidx_q != VLAST) vidx_q <= vidx_q + 1'b1;
          end
        end
        S_WRITE: begin
          voice_step_q[best_q]     <= step_q;
          voice_duration_q[best_q] <= dur_q;
          voice_gain_q[best_q]     <= gain_q;
          voice_mask_q[best_q]     <= mask_q;
          voice_elapsed_q[best_q]  <= '0;
          voice_phase_q[best_q]    <= '0;
        end
        S_ATK: begin
          a_q <= prod_clamp;
          if (!sounding && vidx_q != VLAST) vidx_q <= vidx_q + 1'b1;
        end
        S_REL: begin
          r_q  <= prod_clamp;
          s1_q <= pbs_pkg::sine_lookup(cur_phase);
        end
        S_ENV: begin
          env_q <= prod[32:16];
          s3_q  <= pbs_pkg::sine_lookup(phase3);
        end
        S_GAIN:  g_q    <= prod[32:16];
        S_TONE1: acc_q  <= prod[31:0];
        S_TONE3: tone_q <= tone_sum[32:15];
        S_MIX:   samp_q <= samp_round[32:16];
        S_ADD: begin
          for (int c = 0; c < pbs_pkg::CHANNELS; c++) begin
            if (voice_mask_q[vidx_q][c]) begin
              if (20'(sum_q[c]) + 20'(samp_q) > pbs_pkg::OUT_MAX)
                sum_q[c] <= pbs_pkg::OUT_MAX[18:0];
              else if (20'(sum_q[c]) + 20'(samp_q) < pbs_pkg::OUT_MIN)
                sum_q[c] <= pbs_pkg::OUT_MIN[18:0];
              else
                sum_q[c] <= sum_q[c] + 19'(samp_q);
            end
          end
          voice_phase_q[vidx_q]   <= cur_phase + voice_step_q[vidx_q];
          voice_elapsed_q[vidx_q] <= cur_el + 24'd1;
          if (vidx_q != VLAST) vidx_q <= vidx_q + 1'b1;
        end
        S_OUT: begin
          if (out_free) begin
            for (int c = 0; c < pbs_pkg::OUT_FIELDS; c++)
              m_data_q[c*pbs_pkg::SAMPLE_W +: pbs_pkg::SAMPLE_W] <= sum_q[c];
          end
        end
        default: ;
      endcase
    end
  end

  `PBS_ASSERT(a_frame_from_out, $rose(m_axis_tvalid) |-> $past(state_q) == S_OUT, "frame not from output state")
  `PBS_ASSERT(a_idle_first_voice, (state_q == S_ATK && $past(state_q) == S_IDLE) |-> vidx_q == '0, "tick not at voice 0")
  `PBS_ASSERT(a_write_after_scan, state_q == S_WRITE |-> $past(state_q) == S_SCAN, "voice write without scan")
  `PBS_ASSERT_ALWAYS(a_busy_not_ready, (state_q != S_IDLE) |-> !s_axis_tready, "ready while busy")

endmodule
